// ===== design/clock_divider_planner_defines.svh =====
// Assertion macros for the clock divider planner.
// Used by the top level only; compiled out when SYNTHESIS is defined.
`ifndef CLOCK_DIVIDER_PLANNER_DEFINES_SVH
`define CLOCK_DIVIDER_PLANNER_DEFINES_SVH
`ifndef SYNTHESIS
// check with reset as disable
`define CDP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("clock divider planner check failed");
// check that also holds through reset
`define CDP_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("clock divider planner check failed");
`else
`define CDP_ASSERT(label, clk, rst, prop)
`define CDP_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== design/cdp_pkg.sv =====
// Shared types and constants for the clock divider planner.
// No dependencies; used by cdp_ctrl, cdp_dpath and clock_divider_planner.
`default_nettype none
package cdp_pkg;

   localparam int unsigned RATE_W      = 32;
   localparam int unsigned RATE_REGS   = 4;
   localparam int unsigned CSR_INDEX_W = 3;

   localparam logic [RATE_W-1:0] OSC_RESET_HZ    = 32'd24000000;
   localparam logic [2:0]        MAX_LINEAR_BITS = 3'd4;
   localparam logic [1:0]        MAX_SHIFT_BITS  = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_SOURCE_RATE_0   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SOURCE_RATE_1   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SOURCE_RATE_2   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SOURCE_RATE_3   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_LINEAR_DIV_BITS = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_SHIFT_DIV_BITS  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_MUX_BITS        = 3'd6;

   typedef struct packed {
      logic [RATE_REGS-1:0][RATE_W-1:0] source_rate;
      logic [2:0]                       linear_div_bits;
      logic [1:0]                       shift_div_bits;
      logic [1:0]                       mux_bits;
   } cfg_type;

   typedef struct packed {
      logic load;       // capture target, clear best, restart indices
      logic next_src;   // move to next mux source
      logic div_start;  // load dividend for current candidate
      logic div_step;   // one restoring division step
      logic update;     // compare quotient against best
      logic next_cand;  // next m, wrapping into next p
      logic publish;    // copy best into result registers
   } cmd_type;

   typedef struct packed {
      logic src_absent;
      logic div_last;
      logic last_cand;
      logic last_src;
   } sts_type;

endpackage
`default_nettype wire

// ===== design/cdp_ctrl.sv =====
// Controller for the clock divider planner: sequences the search and owns rsp_valid.
// Depends on cdp_pkg for the command and status structs.
`default_nettype none
module cdp_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   input  wire cdp_pkg::sts_type sts,
   output cdp_pkg::cmd_type     cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SRC  = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_CMP  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SRC;
            end
         end
         ST_SRC: begin
            if (sts.src_absent) begin
               if (sts.last_src) begin
                  state_in = ST_FIN;
               end else begin
                  cmd.next_src = 1'b1;
               end
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            cmd.update = 1'b1;
            state_in   = ST_SRC;
            if (sts.last_cand) begin
               if (sts.last_src) begin
                  state_in = ST_FIN;
               end else begin
                  cmd.next_src = 1'b1;
               end
            end else begin
               cmd.next_cand = 1'b1;
            end
         end
         ST_FIN: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== design/cdp_dpath.sv =====
// Datapath for the clock divider planner: loop indices, serial divider, best tracker.
// Depends on cdp_pkg; driven by commands from cdp_ctrl.
`default_nettype none
module cdp_dpath #(
   parameter int SOURCE_COUNT = 4
) (
   input  wire logic             clock,
   input  wire cdp_pkg::cfg_type cfg,
   input  wire cdp_pkg::cmd_type cmd,
   output cdp_pkg::sts_type      sts,
   input  wire logic [31:0]      req_target_rate,
   output logic [1:0]            rsp_source_select,
   output logic [4:0]            rsp_linear_divider,
   output logic [1:0]            rsp_shift_amount,
   output logic [31:0]           rsp_reached_rate,
   output logic                  rsp_found
);

   logic [31:0] target_ff, target_in;
   logic [1:0]  mux_ff, mux_in;
   logic [1:0]  p_ff, p_in;
   logic [4:0]  m_ff, m_in;
   logic [31:0] quo_ff, quo_in;
   logic [4:0]  rem_ff, rem_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] best_ff, best_in;
   logic [4:0]  best_m_ff, best_m_in;
   logic [1:0]  best_p_ff, best_p_in;
   logic [1:0]  best_mux_ff, best_mux_in;
   logic [1:0]  out_mux_ff, out_mux_in;
   logic [4:0]  out_m_ff, out_m_in;
   logic [1:0]  out_p_ff, out_p_in;
   logic [31:0] out_rate_ff, out_rate_in;
   logic        out_found_ff, out_found_in;

   logic [31:0] src_rate;
   logic [2:0]  lin_bits;
   logic [1:0]  shf_bits;
   logic [4:0]  m_lim;
   logic [1:0]  p_max;
   logic [3:0]  src_raw;
   logic [3:0]  src_lim;
   logic        last_m;
   logic        last_p;
   logic [5:0]  trial;
   logic        qbit;

   assign src_rate = cfg.source_rate[mux_ff];

   // clamp the field widths
   assign lin_bits = (cfg.linear_div_bits > cdp_pkg::MAX_LINEAR_BITS) ?
                     cdp_pkg::MAX_LINEAR_BITS : cfg.linear_div_bits;
   assign shf_bits = (cfg.shift_div_bits > cdp_pkg::MAX_SHIFT_BITS) ?
                     cdp_pkg::MAX_SHIFT_BITS : cfg.shift_div_bits;
   assign m_lim    = 5'd1 << lin_bits;

   always_comb begin
      case (shf_bits)
         2'd0:    p_max = 2'd0;
         2'd1:    p_max = 2'd1;
         default: p_max = 2'd3;
      endcase
   end

   always_comb begin
      src_raw = 4'd1 << cfg.mux_bits;
      src_lim = src_raw;
      if (src_lim > 4'(SOURCE_COUNT)) begin
         src_lim = 4'(SOURCE_COUNT);
      end
      if (src_lim > 4'(cdp_pkg::RATE_REGS)) begin
         src_lim = 4'(cdp_pkg::RATE_REGS);
      end
   end

   assign last_m = (m_ff == m_lim);
   assign last_p = (p_ff == p_max);

   assign sts.src_absent = (src_rate == '0);
   assign sts.div_last   = (cnt_ff == 5'd31);
   assign sts.last_cand  = last_m & last_p;
   assign sts.last_src   = (({2'b00, mux_ff} + 4'd1) == src_lim);

   // restoring step: remainder stays below m, so five bits hold it
   assign trial = {rem_ff, quo_ff[31]};
   assign qbit  = (trial >= {1'b0, m_ff});

   always_comb begin
      target_in    = target_ff;
      mux_in       = mux_ff;
      p_in         = p_ff;
      m_in         = m_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      best_in      = best_ff;
      best_m_in    = best_m_ff;
      best_p_in    = best_p_ff;
      best_mux_in  = best_mux_ff;
      out_mux_in   = out_mux_ff;
      out_m_in     = out_m_ff;
      out_p_in     = out_p_ff;
      out_rate_in  = out_rate_ff;
      out_found_in = out_found_ff;

      if (cmd.load) begin
         target_in   = req_target_rate;
         mux_in      = 2'd0;
         p_in        = 2'd0;
         m_in        = 5'd1;
         best_in     = '0;
         best_m_in   = 5'd1;
         best_p_in   = 2'd0;
         best_mux_in = 2'd0;
      end

      if (cmd.div_start) begin
         quo_in = src_rate >> p_ff;
         rem_in = '0;
         cnt_in = '0;
      end

      if (cmd.div_step) begin
         rem_in = qbit ? 5'(trial - {1'b0, m_ff}) : trial[4:0];
         quo_in = {quo_ff[30:0], qbit};
         cnt_in = cnt_ff + 5'd1;
      end

      // strict compare keeps the earliest candidate on a tie
      if (cmd.update && (quo_ff <= target_ff) && (quo_ff > best_ff)) begin
         best_in     = quo_ff;
         best_m_in   = m_ff;
         best_p_in   = p_ff;
         best_mux_in = mux_ff;
      end

      if (cmd.next_cand) begin
         if (last_m) begin
            m_in = 5'd1;
            p_in = p_ff + 2'd1;
         end else begin
            m_in = m_ff + 5'd1;
         end
      end

      if (cmd.next_src) begin
         mux_in = mux_ff + 2'd1;
         p_in   = 2'd0;
         m_in   = 5'd1;
      end

      if (cmd.publish) begin
         out_mux_in   = best_mux_ff;
         out_m_in     = best_m_ff;
         out_p_in     = best_p_ff;
         out_rate_in  = best_ff;
         out_found_in = (best_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      target_ff    <= target_in;
      mux_ff       <= mux_in;
      p_ff         <= p_in;
      m_ff         <= m_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      best_ff      <= best_in;
      best_m_ff    <= best_m_in;
      best_p_ff    <= best_p_in;
      best_mux_ff  <= best_mux_in;
      out_mux_ff   <= out_mux_in;
      out_m_ff     <= out_m_in;
      out_p_ff     <= out_p_in;
      out_rate_ff  <= out_rate_in;
      out_found_ff <= out_found_in;
   end

   assign rsp_source_select  = out_mux_ff;
   assign rsp_linear_divider = out_m_ff;
   assign rsp_shift_amount   = out_p_ff;
   assign rsp_reached_rate   = out_rate_ff;
   assign rsp_found          = out_found_ff;

endmodule
`default_nettype wire

// ===== design/clock_divider_planner.sv =====
// Clock divider planner. A beat on req_ carries a target rate; one beat on rsp_ returns the
// mux source, linear divider m, shift p and the highest rate (source >> p) / m not above the
// target, with found low when nothing fits. One request is searched at a time. Each
// candidate takes one 32-step serial division plus bookkeeping in the compare state. The search
// covers up to four sources, sixteen m and four p; an absent source skips the division. A new
// request is taken while a finished result still waits. The user must write configuration
// through csr_ only while the block is idle; the block itself does not enforce this.
`default_nettype none
`include "clock_divider_planner_defines.svh"
module clock_divider_planner #(
   parameter int SOURCE_COUNT = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_target_rate,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_source_select,
   output logic [4:0]       rsp_linear_divider,
   output logic [1:0]       rsp_shift_amount,
   output logic [31:0]      rsp_reached_rate,
   output logic             rsp_found,
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   cdp_pkg::cfg_type cfg_ff, cfg_in;
   cdp_pkg::cmd_type cmd;
   cdp_pkg::sts_type sts;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            cdp_pkg::REG_SOURCE_RATE_0:   cfg_in.source_rate[0]  = csr_wdata;
            cdp_pkg::REG_SOURCE_RATE_1:   cfg_in.source_rate[1]  = csr_wdata;
            cdp_pkg::REG_SOURCE_RATE_2:   cfg_in.source_rate[2]  = csr_wdata;
            cdp_pkg::REG_SOURCE_RATE_3:   cfg_in.source_rate[3]  = csr_wdata;
            cdp_pkg::REG_LINEAR_DIV_BITS: cfg_in.linear_div_bits = csr_wdata[2:0];
            cdp_pkg::REG_SHIFT_DIV_BITS:  cfg_in.shift_div_bits  = csr_wdata[1:0];
            cdp_pkg::REG_MUX_BITS:        cfg_in.mux_bits        = csr_wdata[1:0];
            default: begin
               // unused index: write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_rate[0]  <= cdp_pkg::OSC_RESET_HZ;
         cfg_ff.source_rate[1]  <= '0;
         cfg_ff.source_rate[2]  <= '0;
         cfg_ff.source_rate[3]  <= '0;
         cfg_ff.linear_div_bits <= cdp_pkg::MAX_LINEAR_BITS;
         cfg_ff.shift_div_bits  <= cdp_pkg::MAX_SHIFT_BITS;
         cfg_ff.mux_bits        <= 2'd2;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cdp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   cdp_dpath #(
      .SOURCE_COUNT (SOURCE_COUNT)
   ) u_dpath (
      .clock              (clock),
      .cfg                (cfg_ff),
      .cmd                (cmd),
      .sts                (sts),
      .req_target_rate    (req_target_rate),
      .rsp_source_select  (rsp_source_select),
      .rsp_linear_divider (rsp_linear_divider),
      .rsp_shift_amount   (rsp_shift_amount),
      .rsp_reached_rate   (rsp_reached_rate),
      .rsp_found          (rsp_found)
   );

   // found flag must agree with the reached rate
   `CDP_ASSERT(a_found_rate, clock, reset, rsp_valid |-> (rsp_found == (rsp_reached_rate != '0)))
   // m never outside 1..16 on a delivered beat (m - 1 wraps to 31 when m is zero)
   `CDP_ASSERT(a_div_range, clock, reset, rsp_valid |-> (rsp_linear_divider - 5'd1 < 5'd16))
   // a result only appears at the end of a search, when requests were held off
   `CDP_ASSERT(a_result_after_search, clock, reset, $rose(rsp_valid) |-> $past(req_stall))
   // no request can be taken while a command stream is running
   `CDP_ASSERT_ALWAYS(a_no_load_when_busy, clock, (cmd.load |-> !req_stall))

endmodule
`default_nettype wire
